// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the trimmed-mean filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TMAF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition is followed by a property in the next cycle.
`define TMAF_ASSERT_NXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond |=> prop) else $error(msg);

`endif

// ----- hw/rtl/tmaf_pkg.sv -----
// Package with the types and constants of the trimmed-mean filter.
`default_nettype none

package tmaf_pkg;

	// Field widths.
	localparam int SAMPLE_W = 12;
	localparam int MV_W     = 16;
	localparam int STAT_W   = 2;

	// Divider widths: the dividend must hold 3000 times a 12-bit code.
	localparam int DIV_W     = 24;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Defaults and constants.
	localparam int                  BATCH_SIZE_DEF = 24;
	localparam logic [SAMPLE_W-1:0] CAL_RESET      = 12'd1670;
	localparam logic [DIV_W-1:0]    SUPPLY_REF_MV  = 24'd3000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 12'd4095;

	// Supply status codes.
	localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_SAT  = 2'd2;

	// Control of one sorting cell.
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

	// Status of the iterative divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tmaf_in_if.sv -----
// Sample input channel of the trimmed-mean filter.
`default_nettype none

interface tmaf_in_if;
	logic                           valid;
	logic                           ready;
	logic [tmaf_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tmaf_out_if.sv -----
// Result output channel of the trimmed-mean filter.
`default_nettype none

interface tmaf_out_if;
	logic                           valid;
	logic                           ready;
	logic [tmaf_pkg::SAMPLE_W-1:0]  trimmed_mean;
	logic [tmaf_pkg::MV_W-1:0]      supply_mv;
	logic [tmaf_pkg::STAT_W-1:0]    supply_status;

	modport source (output valid, output trimmed_mean, output supply_mv,
		output supply_status, input ready);
	modport sink (input valid, input trimmed_mean, input supply_mv,
		input supply_status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tmaf_cfg_if.sv -----
// Calibration write channel of the trimmed-mean filter.
`default_nettype none

interface tmaf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tmaf_pkg::SAMPLE_W-1:0]  ref_calibration;

	modport source (output valid, output ref_calibration, input ready);
	modport sink (input valid, input ref_calibration, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tmaf_cell.sv -----
// One cell of the insertion-sort chain that holds a single sample.
`default_nettype none

module tmaf_cell (
	input  wire logic                          clk,
	input  wire tmaf_pkg::cell_ctl_t           ctl,
	input  wire logic                          empty,
	input  wire logic [tmaf_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [tmaf_pkg::SAMPLE_W-1:0] left_val,
	input  wire logic                          left_gt,
	output logic      [tmaf_pkg::SAMPLE_W-1:0] val,
	output logic                               gt
);

	logic [tmaf_pkg::SAMPLE_W-1:0] val_q;

	// An empty cell counts as larger than any new sample.
	assign gt  = empty | (val_q > sample);
	assign val = val_q;

	// Insert: take the left neighbor when it moves up, else the sample at the
	// boundary. Drain: take the left neighbor unconditionally.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= left_val;
		end else if (ctl.ins) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt) begin
				val_q <= sample;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tmaf_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module tmaf_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [tmaf_pkg::DIV_W-1:0]    dividend,
	input  wire logic [tmaf_pkg::SAMPLE_W-1:0] divisor,
	output tmaf_pkg::div_stat_t                stat,
	output logic      [tmaf_pkg::DIV_W-1:0]    quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [tmaf_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [tmaf_pkg::DIV_W-1:0]        dvd_q;
	logic [tmaf_pkg::SAMPLE_W-1:0]     dsr_q;
	logic [tmaf_pkg::SAMPLE_W-1:0]     rem_q;
	logic [tmaf_pkg::SAMPLE_W:0]       rem_sh;
	logic [tmaf_pkg::SAMPLE_W+1:0]     diff;
	logic                              qbit;

	// Trial subtraction of the divisor from the shifted remainder.
	assign rem_sh = {rem_q, dvd_q[tmaf_pkg::DIV_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign qbit   = ~diff[tmaf_pkg::SAMPLE_W+1];

	// Sequencing of the division steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tmaf_pkg::DIV_CNT_W'(tmaf_pkg::DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[tmaf_pkg::DIV_W-2:0], qbit};
			rem_q <= qbit ? diff[tmaf_pkg::SAMPLE_W-1:0] : rem_sh[tmaf_pkg::SAMPLE_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

`default_nettype wire

// ----- hw/rtl/trimmed_mean_adc_filter_top.sv -----
// Top level of the trimmed-mean ADC filter with supply-voltage estimate.
//
// Usage: samples arrive on the samples channel and are accepted when valid
// and ready are both high. Each accepted item is inserted into a chain of
// BATCH_SIZE sorting cells, so items may follow back to back while a batch
// fills. After the last item of a batch the chain drains, summing the middle
// third, and samples are refused meanwhile. The mean is then formed as a
// multiplication of the sum by the reciprocal of the third, and an iterative
// divider forms the supply voltage, one quotient bit per cycle. When the
// mean is zero the divider is skipped and the result has the zero status.
// The next batch may fill while the divider works; its last item waits until
// the divider is idle and the previous result has been taken.
// The cfg channel writes the calibration word; it is always ready.
// A stalled results receiver holds the result in the output register.
// Reset clears the batch count, the divider and the output valid, and
// sets the calibration word to 1670.
`default_nettype none
`include "assert_macros.svh"

module trimmed_mean_adc_filter_top #(
	parameter int BATCH_SIZE = tmaf_pkg::BATCH_SIZE_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tmaf_in_if.sink    samples,
	tmaf_out_if.source results,
	tmaf_cfg_if.sink   cfg
);

	localparam int THIRD = BATCH_SIZE / 3;
	localparam int IDX_W = $clog2(BATCH_SIZE);
	localparam int SUM_W = $clog2(THIRD * 4095 + 1);
	localparam logic [IDX_W-1:0] LAST   = IDX_W'(BATCH_SIZE - 1);
	localparam logic [IDX_W-1:0] MID_LO = IDX_W'(THIRD);
	localparam logic [IDX_W-1:0] MID_HI = IDX_W'(2 * THIRD);

	// Reciprocal of the third, exact for every sum of SUM_W bits.
	localparam int     RCP_SH = SUM_W + $clog2(THIRD);
	localparam int     RCP_W  = SUM_W + 2;
	localparam int     PROD_W = SUM_W + RCP_W;
	localparam longint RCP_M  = ((longint'(1) << RCP_SH) + THIRD - 1) / THIRD;

	// Phase codes of the sorting chain.
	localparam logic ST_FILL  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	// Phase codes of the divider sequence.
	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MEAN = 2'd1;
	localparam logic [1:0] P_VOLT = 2'd2;

	logic                           st_q;
	logic [1:0]                     pst_q;
	logic [IDX_W-1:0]               count_q;
	logic [IDX_W-1:0]               idx_q;
	logic [SUM_W-1:0]               acc_q;
	logic [SUM_W-1:0]               sum_next;
	logic [tmaf_pkg::SAMPLE_W-1:0]  cal_q;
	logic [tmaf_pkg::SAMPLE_W-1:0]  mean_q;
	logic                           out_vld_q;
	logic [tmaf_pkg::SAMPLE_W-1:0]  out_mean_q;
	logic [tmaf_pkg::MV_W-1:0]      out_mv_q;
	logic [tmaf_pkg::STAT_W-1:0]    out_stat_q;

	logic                           in_acc;
	logic                           last_ok;
	logic                           drain_end;
	logic                           out_load;
	logic [PROD_W-1:0]              mean_prod;
	logic [tmaf_pkg::SAMPLE_W-1:0]  mean_calc;
	logic [tmaf_pkg::SAMPLE_W-1:0]  load_mean;
	logic [tmaf_pkg::MV_W-1:0]      load_mv;
	logic [tmaf_pkg::STAT_W-1:0]    load_stat;
	logic                           div_start;
	logic [tmaf_pkg::DIV_W-1:0]     div_dvd;
	logic [tmaf_pkg::SAMPLE_W-1:0]  div_dsr;
	tmaf_pkg::div_stat_t            div_stat;
	logic [tmaf_pkg::DIV_W-1:0]     div_quo;
	tmaf_pkg::cell_ctl_t            cell_ctl;

	logic [tmaf_pkg::SAMPLE_W-1:0]  cell_val [BATCH_SIZE];
	logic [BATCH_SIZE-1:0]          cell_gt;

	// The item that completes a batch needs an idle divider and a free output.
	assign last_ok        = (pst_q == P_IDLE) && !out_vld_q;
	assign samples.ready  = (st_q == ST_FILL) && ((count_q != LAST) || last_ok);
	assign in_acc         = samples.valid && samples.ready;
	assign cfg.ready      = 1'b1;
	assign cell_ctl.ins   = in_acc;
	assign cell_ctl.shift = (st_q == ST_DRAIN);

	// Chain of sorting cells, smallest value in cell zero.
	for (genvar i = 0; i < BATCH_SIZE; i++) begin : g_cell
		logic [tmaf_pkg::SAMPLE_W-1:0] left_val;
		logic                          left_gt;
		if (i == 0) begin : g_first
			assign left_val = '0;
			assign left_gt  = 1'b0;
		end else begin : g_rest
			assign left_val = cell_val[i-1];
			assign left_gt  = cell_gt[i-1];
		end
		tmaf_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.empty    (IDX_W'(i) >= count_q),
			.sample   (samples.sample),
			.left_val (left_val),
			.left_gt  (left_gt),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	// Running sum of the middle third as sorted values leave the last cell.
	always_comb begin
		sum_next = acc_q;
		if ((idx_q >= MID_LO) && (idx_q < MID_HI)) begin
			sum_next = acc_q + SUM_W'(cell_val[BATCH_SIZE-1]);
		end
	end

	assign drain_end = (st_q == ST_DRAIN) && (idx_q == MID_LO);

	// Fill and drain sequencing of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_FILL;
			count_q <= '0;
			idx_q   <= '0;
			acc_q   <= '0;
		end else begin
			unique case (st_q)
				ST_FILL: begin
					if (in_acc) begin
						if (count_q == LAST) begin
							st_q  <= ST_DRAIN;
							idx_q <= LAST;
							acc_q <= '0;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					acc_q <= sum_next;
					idx_q <= idx_q - 1'b1;
					if (drain_end) begin
						st_q    <= ST_FILL;
						count_q <= '0;
					end
				end
				default: st_q <= ST_FILL;
			endcase
		end
	end

	// Mean of the middle third from the registered sum times the reciprocal.
	assign mean_prod = PROD_W'(acc_q) * PROD_W'(RCP_M);
	assign mean_calc = mean_prod[RCP_SH +: tmaf_pkg::SAMPLE_W];

	// Divider operands: 3000 times the code by the mean.
	assign div_dvd = tmaf_pkg::SUPPLY_REF_MV * tmaf_pkg::DIV_W'(cal_q);
	assign div_dsr = mean_calc;

	// Result selection and divider start.
	always_comb begin
		div_start = 1'b0;
		out_load  = 1'b0;
		load_mean = mean_q;
		load_mv   = '0;
		load_stat = tmaf_pkg::STATUS_OK;
		unique case (pst_q)
			P_IDLE: ;
			P_MEAN: begin
				load_mean = mean_calc;
				if (mean_calc == '0) begin
					out_load  = 1'b1;
					load_stat = tmaf_pkg::STATUS_ZERO;
				end else begin
					div_start = 1'b1;
				end
			end
			P_VOLT: begin
				if (div_stat.done) begin
					out_load = 1'b1;
					if (div_quo[tmaf_pkg::DIV_W-1:tmaf_pkg::MV_W] != '0) begin
						load_mv   = '1;
						load_stat = tmaf_pkg::STATUS_SAT;
					end else begin
						load_mv = div_quo[tmaf_pkg::MV_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	// Divider sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pst_q <= P_IDLE;
		end else begin
			unique case (pst_q)
				P_IDLE: if (drain_end) pst_q <= P_MEAN;
				P_MEAN: pst_q <= div_start ? P_VOLT : P_IDLE;
				P_VOLT: if (div_stat.done) pst_q <= P_IDLE;
				default: pst_q <= P_IDLE;
			endcase
		end
	end

	// Keep the mean for the result while the voltage is divided.
	always_ff @(posedge clk) begin
		if (pst_q == P_MEAN) begin
			mean_q <= mean_calc;
		end
	end

	tmaf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// Calibration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= tmaf_pkg::CAL_RESET;
		end else if (cfg.valid) begin
			cal_q <= cfg.ref_calibration;
		end
	end

	// Output register holds a result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_mean_q <= load_mean;
			out_mv_q   <= load_mv;
			out_stat_q <= load_stat;
		end
	end

	assign results.valid         = out_vld_q;
	assign results.trimmed_mean  = out_mean_q;
	assign results.supply_mv     = out_mv_q;
	assign results.supply_status = out_stat_q;

	// Checks on the sequencing.
	`TMAF_ASSERT(a_fill_count, (st_q == ST_FILL) |-> (count_q <= LAST), "Fill count beyond batch")
	`TMAF_ASSERT(a_div_idle, div_start |-> !div_stat.busy, "Divider started while busy")
	`TMAF_ASSERT(a_out_free, out_load |-> !out_vld_q, "Result overwrote a pending result")
	`TMAF_ASSERT(a_drain_stall, (st_q == ST_DRAIN) |-> !samples.ready, "Sample taken in drain")
	`TMAF_ASSERT_NXT(a_out_shown, out_load, results.valid, "Loaded result not shown")

endmodule

`default_nettype wire
